[hw/rtl/oss_pkg.sv]
// ----------------------------------------------------------------------------
// oss_pkg
// shared types, codes and constants of the update session sequencer
// ----------------------------------------------------------------------------
package oss_pkg;

	// fixed field widths
	localparam int PLEN_W = 9;
	localparam int WORD_W = 32;
	localparam int CODE_W = 3;

	// default chunk length of the backend
	localparam int CHUNK_LEN_DEF = 4096;
	// longest data payload accepted
	localparam int MAX_DATA_LEN = 256;
	// shortest start payload (size and crc)
	localparam int START_PAYLOAD_MIN = 8;
	// reset value of the plausible size bound
	localparam logic [WORD_W-1:0] MAX_FILE_SIZE_RST = 32'd33554432;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// request kinds
	localparam logic [1:0] REQ_START  = 2'd0;
	localparam logic [1:0] REQ_DATA   = 2'd1;
	localparam logic [1:0] REQ_NOTIFY = 2'd2;
	localparam logic [1:0] REQ_DISC   = 2'd3;

	// backend notification codes
	localparam logic [1:0] NOTE_CONT    = 2'd0;
	localparam logic [1:0] NOTE_FAIL    = 2'd1;
	localparam logic [1:0] NOTE_SUCCESS = 2'd2;
	localparam logic [1:0] NOTE_OTHER   = 2'd3;

	// result kinds
	localparam logic [CODE_W-1:0] KIND_START_REPLY = 3'd0;
	localparam logic [CODE_W-1:0] KIND_DATA_REPLY  = 3'd1;
	localparam logic [CODE_W-1:0] KIND_FWD_START   = 3'd2;
	localparam logic [CODE_W-1:0] KIND_FWD_DATA    = 3'd3;
	localparam logic [CODE_W-1:0] KIND_FWD_END     = 3'd4;

	// reply codes
	localparam logic [CODE_W-1:0] REPLY_ALLOWED     = 3'd0;
	localparam logic [CODE_W-1:0] REPLY_NOT_ALLOWED = 3'd1;
	localparam logic [CODE_W-1:0] REPLY_CONTINUE    = 3'd2;
	localparam logic [CODE_W-1:0] REPLY_FAIL        = 3'd3;
	localparam logic [CODE_W-1:0] REPLY_FINISH      = 3'd4;

	// reasons
	localparam logic [CODE_W-1:0] WHY_NONE       = 3'd0;
	localparam logic [CODE_W-1:0] WHY_INVALID    = 3'd1;
	localparam logic [CODE_W-1:0] WHY_BUSY       = 3'd2;
	localparam logic [CODE_W-1:0] WHY_NOT_READY  = 3'd3;
	localparam logic [CODE_W-1:0] WHY_OVERFLOW   = 3'd4;
	localparam logic [CODE_W-1:0] WHY_DATA       = 3'd5;
	localparam logic [CODE_W-1:0] WHY_END        = 3'd6;
	localparam logic [CODE_W-1:0] WHY_START_FAIL = 3'd7;

	// one result without its wide payload
	typedef struct packed {
		logic [CODE_W-1:0] kind;
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] why;
	} res_t;

	// everything one item emits, handed from front to back
	typedef struct packed {
		logic [1:0]        cnt;
		res_t [2:0]        res;
		logic [WORD_W-1:0] size;
		logic [WORD_W-1:0] crc;
		logic [PLEN_W-1:0] len;
	} plan_t;

	function automatic res_t mk_res(logic [CODE_W-1:0] kind, logic [CODE_W-1:0] code,
			logic [CODE_W-1:0] why);
		res_t r;
		r.kind = kind;
		r.code = code;
		r.why  = why;
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] swap32(logic [WORD_W-1:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

[hw/rtl/oss_front.sv]
// ----------------------------------------------------------------------------
// oss_front
// accepts items, updates the session state and plans the results
// ----------------------------------------------------------------------------
module oss_front #(
	parameter int CHUNK_LEN = oss_pkg::CHUNK_LEN_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [oss_pkg::WORD_W-1:0] cfg_wdata,
	input  logic                      take,
	input  logic [1:0]                req_type,
	input  logic [oss_pkg::PLEN_W-1:0] body_len,
	input  logic [oss_pkg::WORD_W-1:0] size_raw,
	input  logic [oss_pkg::WORD_W-1:0] crc_raw,
	input  logic [1:0]                notify_code,
	input  logic                      fwd_ok,
	input  logic                      end_ok,
	output logic                      plan_push,
	output oss_pkg::plan_t            plan
);
	import oss_pkg::*;

	localparam int CW   = $clog2(CHUNK_LEN);
	localparam int PMAX = 2 ** PLEN_W - 1;
	localparam int QB   = (PMAX >= CHUNK_LEN) ? $clog2(PMAX / CHUNK_LEN + 1) : 0;

	logic [WORD_W-1:0] max_file_size_q;
	logic              session_on_q, start_wait_q, end_wait_q, final_wait_q;
	logic [WORD_W-1:0] target_size_q, target_crc_q, bytes_seen_q;
	logic [CW-1:0]     chunk_rem_q;

	logic              session_on_d, start_wait_d, end_wait_d, final_wait_d;
	logic [WORD_W-1:0] target_size_d, target_crc_d, bytes_seen_d;
	logic [CW-1:0]     chunk_rem_d;
	logic              do_clear;

	logic [WORD_W-1:0] size_pick, crc_pick;
	logic [WORD_W:0]   next_sum;
	logic              over, at_end;
	logic [PLEN_W-1:0] plen_mod;
	logic [CW:0]       rem_sum;
	logic [CW-1:0]     rem_new;

	// keep received order unless only the swapped one is plausible
	function automatic logic [WORD_W-1:0] pick_order(logic [WORD_W-1:0] v,
			logic [WORD_W-1:0] lim);
		logic [WORD_W-1:0] o;
		logic              a_ok, b_ok;
		o    = swap32(v);
		a_ok = (v != '0) && (v <= lim);
		b_ok = (o != '0) && (o <= lim);
		return (!a_ok && b_ok) ? o : v;
	endfunction

	assign size_pick = pick_order(size_raw, max_file_size_q);
	assign crc_pick  = pick_order(crc_raw, max_file_size_q);

	assign next_sum = {1'b0, bytes_seen_q} + (WORD_W+1)'(body_len);
	assign over     = next_sum > {1'b0, target_size_q};
	assign at_end   = next_sum[WORD_W-1:0] == target_size_q;

	// payload length modulo chunk length, restoring steps on a narrow value
	always_comb begin
		plen_mod = body_len;
		for (int k = QB - 1; k >= 0; k--) begin
			if (32'(plen_mod) >= 32'(CHUNK_LEN << k)) begin
				plen_mod = plen_mod - PLEN_W'(CHUNK_LEN << k);
			end
		end
	end

	assign rem_sum = (CW+1)'(chunk_rem_q) + (CW+1)'(plen_mod);
	assign rem_new = (rem_sum >= (CW+1)'(CHUNK_LEN)) ?
		CW'(rem_sum - (CW+1)'(CHUNK_LEN)) : CW'(rem_sum);

	always_comb begin
		plan          = '0;
		session_on_d  = session_on_q;
		start_wait_d  = start_wait_q;
		end_wait_d    = end_wait_q;
		final_wait_d  = final_wait_q;
		target_size_d = target_size_q;
		target_crc_d  = target_crc_q;
		bytes_seen_d  = bytes_seen_q;
		chunk_rem_d   = chunk_rem_q;
		do_clear      = 1'b0;
		case (req_type)
			REQ_START: begin
				plan.cnt = 2'd1;
				if (body_len < PLEN_W'(START_PAYLOAD_MIN)) begin
					plan.res[0] = mk_res(KIND_START_REPLY, REPLY_NOT_ALLOWED, WHY_INVALID);
				end else if (session_on_q) begin
					plan.res[0] = mk_res(KIND_START_REPLY, REPLY_NOT_ALLOWED, WHY_BUSY);
				end else begin
					plan.res[0]   = mk_res(KIND_FWD_START, '0, '0);
					plan.size     = size_pick;
					plan.crc      = crc_pick;
					session_on_d  = 1'b1;
					start_wait_d  = 1'b1;
					end_wait_d    = 1'b0;
					final_wait_d  = 1'b0;
					target_size_d = size_pick;
					target_crc_d  = crc_pick;
					bytes_seen_d  = '0;
					chunk_rem_d   = '0;
					if (!fwd_ok) begin
						plan.cnt    = 2'd2;
						plan.res[1] = mk_res(KIND_START_REPLY, REPLY_NOT_ALLOWED,
							WHY_START_FAIL);
						do_clear    = 1'b1;
					end
				end
			end
			REQ_DATA: begin
				plan.cnt = 2'd1;
				if (body_len == '0 || 32'(body_len) > 32'(MAX_DATA_LEN)) begin
					plan.res[0] = mk_res(KIND_DATA_REPLY, REPLY_FAIL, WHY_INVALID);
				end else if (!session_on_q || start_wait_q) begin
					plan.res[0] = mk_res(KIND_DATA_REPLY, REPLY_FAIL, WHY_NOT_READY);
				end else if (final_wait_q || end_wait_q) begin
					plan.res[0] = mk_res(KIND_DATA_REPLY, REPLY_FAIL, WHY_BUSY);
				end else if (over) begin
					plan.res[0] = mk_res(KIND_DATA_REPLY, REPLY_FAIL, WHY_OVERFLOW);
					do_clear    = 1'b1;
				end else begin
					plan.res[0] = mk_res(KIND_FWD_DATA, '0, '0);
					plan.len    = body_len;
					if (!fwd_ok) begin
						plan.cnt    = 2'd2;
						plan.res[1] = mk_res(KIND_DATA_REPLY, REPLY_FAIL, WHY_DATA);
						do_clear    = 1'b1;
					end else begin
						bytes_seen_d = next_sum[WORD_W-1:0];
						chunk_rem_d  = rem_new;
						if (!at_end) begin
							plan.cnt    = 2'd2;
							plan.res[1] = mk_res(KIND_DATA_REPLY, REPLY_CONTINUE, WHY_NONE);
						end else begin
							final_wait_d = 1'b1;
							if (rem_new != '0) begin
								plan.cnt    = 2'd2;
								plan.res[1] = mk_res(KIND_FWD_END, '0, '0);
								if (!end_ok) begin
									plan.cnt    = 2'd3;
									plan.res[2] = mk_res(KIND_DATA_REPLY, REPLY_FAIL, WHY_END);
									do_clear    = 1'b1;
								end
							end else begin
								end_wait_d = 1'b1;
							end
						end
					end
				end
			end
			REQ_NOTIFY: begin
				if (session_on_q) begin
					if (start_wait_q) begin
						start_wait_d = 1'b0;
						plan.cnt     = 2'd1;
						if (notify_code == NOTE_CONT) begin
							plan.res[0] = mk_res(KIND_START_REPLY, REPLY_ALLOWED, WHY_NONE);
						end else begin
							plan.res[0] = mk_res(KIND_START_REPLY, REPLY_NOT_ALLOWED,
								WHY_START_FAIL);
							do_clear    = 1'b1;
						end
					end else if (notify_code == NOTE_FAIL) begin
						plan.cnt    = 2'd1;
						plan.res[0] = mk_res(KIND_DATA_REPLY, REPLY_FAIL, WHY_DATA);
						do_clear    = 1'b1;
					end else if (end_wait_q && notify_code == NOTE_CONT) begin
						end_wait_d  = 1'b0;
						plan.cnt    = 2'd1;
						plan.res[0] = mk_res(KIND_FWD_END, '0, '0);
						if (!end_ok) begin
							plan.cnt    = 2'd2;
							plan.res[1] = mk_res(KIND_DATA_REPLY, REPLY_FAIL, WHY_END);
							do_clear    = 1'b1;
						end
					end else if (final_wait_q && notify_code == NOTE_SUCCESS) begin
						plan.cnt    = 2'd1;
						plan.res[0] = mk_res(KIND_DATA_REPLY, REPLY_FINISH, WHY_NONE);
						do_clear    = 1'b1;
					end
				end
			end
			REQ_DISC: begin
				do_clear = 1'b1;
			end
			default: begin
				do_clear = 1'b1;
			end
		endcase
		if (do_clear) begin
			session_on_d  = 1'b0;
			start_wait_d  = 1'b0;
			end_wait_d    = 1'b0;
			final_wait_d  = 1'b0;
			target_size_d = '0;
			target_crc_d  = '0;
			bytes_seen_d  = '0;
			chunk_rem_d   = '0;
		end
	end

	// items with no result leave nothing for the back
	assign plan_push = take && (plan.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_file_size_q <= MAX_FILE_SIZE_RST;
			session_on_q    <= 1'b0;
			start_wait_q    <= 1'b0;
			end_wait_q      <= 1'b0;
			final_wait_q    <= 1'b0;
			target_size_q   <= '0;
			target_crc_q    <= '0;
			bytes_seen_q    <= '0;
			chunk_rem_q     <= '0;
		end else begin
			if (cfg_wen) begin
				max_file_size_q <= cfg_wdata;
			end
			if (take) begin
				session_on_q  <= session_on_d;
				start_wait_q  <= start_wait_d;
				end_wait_q    <= end_wait_d;
				final_wait_q  <= final_wait_d;
				target_size_q <= target_size_d;
				target_crc_q  <= target_crc_d;
				bytes_seen_q  <= bytes_seen_d;
				chunk_rem_q   <= chunk_rem_d;
			end
		end
	end

endmodule

[hw/rtl/oss_queue.sv]
// ----------------------------------------------------------------------------
// oss_queue
// short queue of result plans between front and back
// ----------------------------------------------------------------------------
module oss_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  oss_pkg::plan_t wr_data,
	input  logic           rd,
	output oss_pkg::plan_t rd_data,
	output logic           full,
	output logic           empty
);
	import oss_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	plan_t           mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PW:0]     count_q;
	logic            do_wr, do_rd;

	assign full    = count_q == (PW+1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

[hw/rtl/oss_back.sv]
// ----------------------------------------------------------------------------
// oss_back
// walks the results of the oldest plan, one beat per pop
// ----------------------------------------------------------------------------
module oss_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  oss_pkg::plan_t             head,
	input  logic                       head_empty,
	input  logic                       pop,
	output logic                       head_done,
	output logic [oss_pkg::CODE_W-1:0] out_kind,
	output logic [oss_pkg::CODE_W-1:0] reply_code,
	output logic [oss_pkg::CODE_W-1:0] reason,
	output logic [oss_pkg::WORD_W-1:0] fwd_size,
	output logic [oss_pkg::WORD_W-1:0] fwd_crc,
	output logic [oss_pkg::PLEN_W-1:0] fwd_len,
	output logic                       last
);
	import oss_pkg::*;

	logic [1:0] idx_q;
	res_t       cur;
	logic       beat;

	always_comb begin
		case (idx_q)
			2'd0:    cur = head.res[0];
			2'd1:    cur = head.res[1];
			2'd2:    cur = head.res[2];
			default: cur = head.res[0];
		endcase
	end

	assign out_kind   = cur.kind;
	assign reply_code = cur.code;
	assign reason     = cur.why;
	assign fwd_size   = (cur.kind == KIND_FWD_START) ? head.size : '0;
	assign fwd_crc    = (cur.kind == KIND_FWD_START) ? head.crc : '0;
	assign fwd_len    = (cur.kind == KIND_FWD_DATA) ? head.len : '0;
	assign last       = idx_q == (head.cnt - 2'd1);

	assign beat      = pop && !head_empty;
	assign head_done = beat && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (beat) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

[hw/rtl/ota_session_sequencer_core.sv]
// ----------------------------------------------------------------------------
// ota_session_sequencer_core
// firmware update session sequencer: start/data/notify/disconnect in,
// backend forwards and application replies out
// ----------------------------------------------------------------------------
//
//  channel   handshake            beat content
//  --------  -------------------  ------------------------------------------
//  request   push / full          req_type, body_len, size_raw, crc_raw,
//                                 notify_code, fwd_ok, end_ok
//  result    empty / pop          out_kind, reply_code, reason, fwd_size,
//                                 fwd_crc, fwd_len, last
//  config    cfg_wen              cfg_wdata -> max_file_size
//
//  the front takes one request beat per cycle while the plan queue has room
//  and updates the session state in that same cycle
//  each request yields zero to three result beats; its plan is written into
//  the plan queue, and its first result shows on the ports once that plan is
//  the queue head; one result leaves per cycle while pop is asserted, and
//  full rises only when all plan queue entries hold unfinished plans
//  reset clears the session and loads max_file_size with 32 MiB
//
module ota_session_sequencer_core #(
	parameter int CHUNK_LEN = oss_pkg::CHUNK_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_wen,
	input  logic [oss_pkg::WORD_W-1:0] cfg_wdata,
	// request side
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 req_type,
	input  logic [oss_pkg::PLEN_W-1:0] body_len,
	input  logic [oss_pkg::WORD_W-1:0] size_raw,
	input  logic [oss_pkg::WORD_W-1:0] crc_raw,
	input  logic [1:0]                 notify_code,
	input  logic                       fwd_ok,
	input  logic                       end_ok,
	// result side
	output logic                       empty,
	input  logic                       pop,
	output logic [oss_pkg::CODE_W-1:0] out_kind,
	output logic [oss_pkg::CODE_W-1:0] reply_code,
	output logic [oss_pkg::CODE_W-1:0] reason,
	output logic [oss_pkg::WORD_W-1:0] fwd_size,
	output logic [oss_pkg::WORD_W-1:0] fwd_crc,
	output logic [oss_pkg::PLEN_W-1:0] fwd_len,
	output logic                       last
);
	import oss_pkg::*;

	logic  take;
	logic  plan_push;
	plan_t plan;
	plan_t head;
	logic  head_done;

	// a request beat is taken whenever the queue can hold its plan
	assign take = push && !full;

	oss_front #(
		.CHUNK_LEN(CHUNK_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.take       (take),
		.req_type   (req_type),
		.body_len   (body_len),
		.size_raw   (size_raw),
		.crc_raw    (crc_raw),
		.notify_code(notify_code),
		.fwd_ok     (fwd_ok),
		.end_ok     (end_ok),
		.plan_push  (plan_push),
		.plan       (plan)
	);

	// plans wait here so front and back stall independently
	oss_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (plan_push),
		.wr_data(plan),
		.rd     (head_done),
		.rd_data(head),
		.full   (full),
		.empty  (empty)
	);

	// result beats come straight from the registered queue head
	oss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_empty(empty),
		.pop       (pop),
		.head_done (head_done),
		.out_kind  (out_kind),
		.reply_code(reply_code),
		.reason    (reason),
		.fwd_size  (fwd_size),
		.fwd_crc   (fwd_crc),
		.fwd_len   (fwd_len),
		.last      (last)
	);

endmodule
